>>> src/lfd_pkg.sv
// lfd_pkg: shared types and constants for the length frame deframer
// holds the result kind codes, register indexes and the structs between modules
// no dependencies
package lfd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned INDEX_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA     = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_TOO_LONG = 2'd2,
        KIND_BAD_END  = 2'd3
    } kind_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_START_MARKER = 2'd0,
        REG_END_MARKER   = 2'd1,
        REG_MAX_PAYLOAD  = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd0;
    localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'd0;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET  = 8'd255;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] end_marker;
        logic [BYTE_W-1:0] max_payload;
    } cfg_t;

    // word held in the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } stage_t;

endpackage

>>> src/lfd_in_if.sv
// lfd_in_if: valid/ready channel carrying one received byte per word
// no dependencies
interface lfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> src/lfd_out_if.sv
// lfd_out_if: valid/ready channel carrying one deframer result per word
// no dependencies
interface lfd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_length;

    modport source (output valid, output kind, output payload_byte, output frame_length,
                    input ready);
    modport sink (input valid, input kind, input payload_byte, input frame_length,
                  output ready);
endinterface

>>> src/lfd_cfg_regs.sv
// lfd_cfg_regs: configuration register file with index decode
// depends on lfd_pkg
module lfd_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [lfd_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [lfd_pkg::BYTE_W-1:0]   cfg_wdata,
    output lfd_pkg::cfg_t                cfg
);
    import lfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_START_MARKER: cfg_next.start_marker = cfg_wdata;
                REG_END_MARKER:   cfg_next.end_marker   = cfg_wdata;
                REG_MAX_PAYLOAD:  cfg_next.max_payload  = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker <= START_MARKER_RESET;
            cfg_reg.end_marker   <= END_MARKER_RESET;
            cfg_reg.max_payload  <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/lfd_in_stage.sv
// lfd_in_stage: input register in front of the frame parser
// depends on lfd_pkg and lfd_in_if
module lfd_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    lfd_in_if.sink           in_ch,
    input  logic             advance,
    output lfd_pkg::stage_t  stage
);
    import lfd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              take;

    // refill in the same cycle the held word moves on
    assign in_ch.ready = !valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= in_ch.rx_byte;
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

>>> src/lfd_parser.sv
// lfd_parser: frame state machine and result register
// depends on lfd_pkg and lfd_out_if
module lfd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  lfd_pkg::stage_t  stage,
    input  lfd_pkg::cfg_t    cfg,
    output logic             advance,
    lfd_out_if.source        out_ch
);
    import lfd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2,
        PH_END    = 2'd3
    } phase_t;

    phase_t            phase_reg,  phase_next;
    logic [BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] held_length_reg, held_length_next;
    logic              res_valid_reg, res_valid_next;
    kind_t             res_kind_reg, res_kind_next;
    logic [BYTE_W-1:0] res_data_reg, res_data_next;
    logic [BYTE_W-1:0] res_len_reg, res_len_next;

    logic              emit;
    kind_t             emit_kind;
    logic [BYTE_W-1:0] emit_data;
    logic [BYTE_W-1:0] emit_len;
    logic [BYTE_W-1:0] b;

    assign b       = stage.data;
    // old result is gone or leaves this cycle
    assign advance = stage.valid && (!res_valid_reg || out_ch.ready);

    always_comb
    begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        held_length_next = held_length_reg;
        emit             = 1'b0;
        emit_kind        = KIND_DATA;
        emit_data        = '0;
        emit_len         = held_length_reg;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (b == cfg.start_marker)
                    phase_next = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                held_length_next = b;
                if (b > cfg.max_payload)
                begin
                    phase_next      = PH_HUNT;
                    bytes_left_next = '0;
                    emit            = 1'b1;
                    emit_kind       = KIND_TOO_LONG;
                    emit_len        = b;
                end
                else
                begin
                    bytes_left_next = b;
                    phase_next      = (b == '0) ? PH_END : PH_DATA;
                end
            end
            PH_DATA:
            begin
                bytes_left_next = bytes_left_reg - 8'd1;
                if (bytes_left_reg == 8'd1)
                    phase_next = PH_END;
                emit      = 1'b1;
                emit_kind = KIND_DATA;
                emit_data = b;
            end
            PH_END:
            begin
                phase_next      = PH_HUNT;
                bytes_left_next = '0;
                emit            = 1'b1;
                emit_kind       = (b == cfg.end_marker) ? KIND_GOOD : KIND_BAD_END;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_kind_next  = res_kind_reg;
        res_data_next  = res_data_reg;
        res_len_next   = res_len_reg;
        if (advance)
        begin
            res_valid_next = emit;
            res_kind_next  = emit_kind;
            res_data_next  = emit_data;
            res_len_next   = emit_len;
        end
        else if (out_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            bytes_left_reg  <= '0;
            held_length_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                phase_reg       <= phase_next;
                bytes_left_reg  <= bytes_left_next;
                held_length_reg <= held_length_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_kind_reg <= res_kind_next;
        res_data_reg <= res_data_next;
        res_len_reg  <= res_len_next;
    end

    assign out_ch.valid        = res_valid_reg;
    assign out_ch.kind         = res_kind_reg;
    assign out_ch.payload_byte = res_data_reg;
    assign out_ch.frame_length = res_len_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !out_ch.ready) |-> !advance)
        else $error("result overwritten while stalled");

    // only payload results carry data
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_kind_reg != KIND_DATA) |-> (res_data_reg == '0))
        else $error("nonzero payload byte on a status result");

    // while receiving payload at least one byte is still due
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (bytes_left_reg != '0))
        else $error("payload phase with no bytes left");

    // an oversize length goes straight back to hunting with an error result
    a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_LENGTH && b > cfg.max_payload)
        |=> (phase_reg == PH_HUNT && res_valid_reg && res_kind_reg == KIND_TOO_LONG))
        else $error("length error not handled");

endmodule

>>> src/length_frame_deframer.sv
// length_frame_deframer: top level of the start/length/end byte deframer
// depends on lfd_pkg, lfd_in_if, lfd_out_if, lfd_cfg_regs, lfd_in_stage, lfd_parser
//
// usage
//   in_ch carries one received byte per word; out_ch carries one result word:
//   kind (payload byte, frame good, length too long, bad end marker),
//   payload_byte and frame_length. bytes outside a frame and the start marker
//   and length byte of an accepted frame give no result word.
//   configuration is a write port: cfg_we, cfg_index (0 start marker, 1 end
//   marker, 2 max payload), cfg_wdata; index 3 is ignored. write only while idle.
//   flow: an accepted byte is held in the input register and parsed from there;
//   its result is loaded into the result register when the byte moves on.
//   throughput: one byte per cycle while out_ch.ready is high; the frame state
//   updates as a byte moves from the input register to the result register.
//   reset: hunting for the start marker, both markers 0, max payload 255,
//   no word held.
//   stall: when out_ch.ready is low a result waits in its register; the input
//   register still takes a byte, and further bytes wait until the result leaves.
//   downstream is to drop payload words of an errored frame; the block emits them.
module length_frame_deframer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [lfd_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [lfd_pkg::BYTE_W-1:0]   cfg_wdata,
    lfd_in_if.sink                       in_ch,
    lfd_out_if.source                    out_ch
);
    import lfd_pkg::*;

    cfg_t   cfg;
    stage_t stage;
    logic   advance;

    lfd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lfd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .advance (advance),
        .stage   (stage)
    );

    lfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .cfg     (cfg),
        .advance (advance),
        .out_ch  (out_ch)
    );

endmodule

>>> test/length_frame_deframer_tb.sv
// length_frame_deframer_tb: self-checking bench for the start/length/end byte deframer
// drives bytes and register writes, predicts every result word and compares in order
// depends on lfd_pkg, lfd_in_if, lfd_out_if and length_frame_deframer from src
module length_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfd_pkg::*;

    localparam int unsigned DRAIN      = 4;
    localparam int unsigned STALL_MAX  = 2000;
    localparam int unsigned HOLD_LEN   = 60;
    localparam int unsigned PHASE_LEN  = 75;
    localparam int unsigned NUM_PHASES = 8;
    localparam int unsigned REPORT_MAX = 10;

    typedef enum logic [1:0] {
        HUNT,
        GET_LEN,
        BODY,
        TAIL
    } frame_phase_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] payload;
        logic [BYTE_W-1:0] frame_len;
    } frame_word_t;

    typedef struct packed {
        bit                is_reg;
        reg_index_t        index;
        logic [BYTE_W-1:0] value;
        bit                typed;
        kind_t             kind;
        logic [BYTE_W-1:0] frame_len;
    } step_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we;
    logic [INDEX_W-1:0]  cfg_index;
    logic [BYTE_W-1:0]   cfg_wdata;

    lfd_in_if  in_ch ();
    lfd_out_if out_ch ();

    length_frame_deframer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state and its copy of the registers
    frame_phase_t        frame_phase = HUNT;
    logic [BYTE_W-1:0]   bytes_left = '0;
    logic [BYTE_W-1:0]   held_len = '0;
    logic [BYTE_W-1:0]   start_byte = START_MARKER_RESET;
    logic [BYTE_W-1:0]   end_byte = END_MARKER_RESET;
    logic [BYTE_W-1:0]   max_len = MAX_PAYLOAD_RESET;

    frame_word_t         pending_words [$];
    logic [BYTE_W-1:0]   byte_stream [$];
    bit                  word_typed;
    frame_word_t         word_hand;
    int unsigned         sender_idle = 0;
    int unsigned         receiver_stall = 0;
    bit                  pressure_on = 1'b0;
    bit                  hold_off = 1'b0;
    int unsigned         mismatches = 0;
    int unsigned         bytes_in = 0;
    int unsigned         words_out = 0;
    int unsigned         kind_seen [4] = '{0, 0, 0, 0};
    int unsigned         quiet_cycles = 0;

    // advances the frame state by one byte; returns 1 when a result word comes out
    function automatic bit deframe(input logic [BYTE_W-1:0] b, output frame_word_t w);
        w = '{KIND_DATA, 8'h00, 8'h00};
        deframe = 1'b0;
        case (frame_phase)
            HUNT:
            begin
                if (b == start_byte)
                    frame_phase = GET_LEN;
            end
            GET_LEN:
            begin
                held_len = b;
                if (b > max_len)
                begin
                    frame_phase = HUNT;
                    bytes_left = '0;
                    w = '{KIND_TOO_LONG, 8'h00, b};
                    deframe = 1'b1;
                end
                else
                begin
                    bytes_left = b;
                    frame_phase = (b == 8'h00) ? TAIL : BODY;
                end
            end
            BODY:
            begin
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'h00)
                    frame_phase = TAIL;
                w = '{KIND_DATA, b, held_len};
                deframe = 1'b1;
            end
            default:
            begin
                frame_phase = HUNT;
                bytes_left = '0;
                w = '{(b == end_byte) ? KIND_GOOD : KIND_BAD_END, 8'h00, held_len};
                deframe = 1'b1;
            end
        endcase
    endfunction

    always @(posedge clk)
    begin : scoreboard
        frame_word_t predicted;
        frame_word_t want;
        frame_word_t got;
        bit          has_word;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                bytes_in++;
                has_word = deframe(in_ch.rx_byte, predicted);
                if (word_typed)
                    pending_words.push_back(word_hand);
                else if (has_word)
                    pending_words.push_back(predicted);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{kind_t'(out_ch.kind), out_ch.payload_byte, out_ch.frame_length};
                words_out++;
                kind_seen[out_ch.kind]++;
                if (pending_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected word: kind %0d byte %02h len %02h",
                                 got.kind, got.payload, got.frame_len);
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("word %0d: expected %0d/%02h/%02h, got %0d/%02h/%02h",
                                     words_out, want.kind, want.payload, want.frame_len,
                                     got.kind, got.payload, got.frame_len);
                    end
                end
            end
        end
    end

    // nothing accepted on either side for too long means the block is stuck
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= !hold_off && ($urandom_range(99) >= receiver_stall);
        end
    end

    // long receiver hold-off while the sender keeps offering bytes
    initial
    begin
        wait (pressure_on);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_off <= 1'b0;
    end

    task automatic send_word(input logic [BYTE_W-1:0] b, input bit typed,
                             input frame_word_t hand);
        while ($urandom_range(99) < sender_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        word_typed    <= typed;
        word_hand     <= hand;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // waits until every expected word is out and the input register has drained
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [BYTE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_START_MARKER: start_byte = val;
            REG_END_MARKER:   end_byte = val;
            REG_MAX_PAYLOAD:  max_len = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // frames with random content under the current markers, plus noise and broken frames
    task automatic build_stream(input int unsigned target);
        int unsigned n;
        int unsigned pick;
        int unsigned len;
        int unsigned top;
        n = 0;
        while (n < target)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                repeat ($urandom_range(4, 1)) byte_stream.push_back(8'($urandom));
            end
            else if (pick < 22 && max_len != 8'hFF)
            begin
                byte_stream.push_back(start_byte);
                byte_stream.push_back(8'($urandom_range(255, int'(max_len) + 1)));
                n += 2;
            end
            else
            begin
                top = (max_len < 8) ? max_len : 8;
                len = ($urandom_range(39) == 0) ? max_len : $urandom_range(top, 0);
                byte_stream.push_back(start_byte);
                byte_stream.push_back(8'(len));
                repeat (len) byte_stream.push_back(8'($urandom));
                // broken tail: wrong end byte
                if ($urandom_range(99) < 20)
                    byte_stream.push_back(($urandom_range(1) == 0) ? ~end_byte
                                          : 8'($urandom));
                else
                    byte_stream.push_back(end_byte);
                n += len + 3;
            end
        end
        // leave a header open so the next register writes land mid-frame
        if ($urandom_range(1) == 0 && max_len != 8'h00)
        begin
            byte_stream.push_back(start_byte);
            byte_stream.push_back(8'($urandom_range(int'(max_len) < 6 ? max_len : 6, 1)));
        end
    endtask

    function automatic step_t reg_step(input reg_index_t idx, input logic [BYTE_W-1:0] val);
        reg_step = '{1'b1, idx, val, 1'b0, KIND_DATA, 8'h00};
    endfunction

    function automatic step_t rx(input logic [BYTE_W-1:0] b);
        rx = '{1'b0, REG_UNUSED, b, 1'b0, KIND_DATA, 8'h00};
    endfunction

    function automatic step_t rx_hand(input logic [BYTE_W-1:0] b, input kind_t k,
                                      input logic [BYTE_W-1:0] len);
        rx_hand = '{1'b0, REG_UNUSED, b, 1'b1, k, len};
    endfunction

    initial
    begin : stimulus
        step_t       plan [];
        logic [BYTE_W-1:0] b;
        int unsigned mode;

        cfg_we        = 1'b0;
        cfg_index     = REG_START_MARKER;
        cfg_wdata     = '0;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = '0;
        word_typed    = 1'b0;
        word_hand     = '{KIND_DATA, 8'h00, 8'h00};

        plan = '{
            reg_step(REG_START_MARKER, 8'hA5), reg_step(REG_END_MARKER, 8'h5A),
            reg_step(REG_MAX_PAYLOAD, 8'd4),
            rx(8'h00), rx(8'hFF),
            rx(8'hA5), rx_hand(8'h05, KIND_TOO_LONG, 8'h05),
            // zero length goes straight to the end marker
            rx(8'hA5), rx(8'h00), rx_hand(8'h5A, KIND_GOOD, 8'h00),
            rx(8'hA5), rx(8'h04), rx(8'hFF), rx(8'h00), rx(8'h80), rx(8'h01),
            rx_hand(8'h5A, KIND_GOOD, 8'h04),
            // rejected length equal to the start marker is not rescanned
            rx(8'hA5), rx_hand(8'hA5, KIND_TOO_LONG, 8'hA5), rx(8'h02),
            rx(8'hA5), rx(8'h01), rx(8'h7E), rx_hand(8'hA5, KIND_BAD_END, 8'h01),
            reg_step(REG_MAX_PAYLOAD, 8'h00), reg_step(REG_START_MARKER, 8'hFF),
            reg_step(REG_END_MARKER, 8'hFF), reg_step(REG_UNUSED, 8'h00),
            // equal markers, each only in its own phase
            rx(8'hFF), rx(8'h00), rx_hand(8'hFF, KIND_GOOD, 8'h00),
            rx(8'hFF), rx_hand(8'hFF, KIND_TOO_LONG, 8'hFF)
        };

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                settle();
                write_reg(plan[i].index, plan[i].value);
            end
            else
                send_word(plan[i].value, plan[i].typed,
                          frame_word_t'{plan[i].kind, 8'h00, plan[i].frame_len});
        end

        for (int unsigned p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    write_reg(REG_START_MARKER, 8'h7E);
                    write_reg(REG_END_MARKER, 8'h7E);
                    write_reg(REG_MAX_PAYLOAD, 8'hFF);
                end
                1:
                begin
                    write_reg(REG_START_MARKER, 8'h00);
                    write_reg(REG_END_MARKER, 8'hFF);
                    write_reg(REG_MAX_PAYLOAD, 8'h00);
                end
                2:
                begin
                    write_reg(REG_START_MARKER, 8'hFF);
                    write_reg(REG_END_MARKER, 8'h00);
                    write_reg(REG_MAX_PAYLOAD, 8'd16);
                end
                default:
                begin
                    write_reg(REG_START_MARKER, 8'($urandom));
                    write_reg(REG_END_MARKER, 8'($urandom));
                    write_reg(REG_MAX_PAYLOAD, 8'($urandom_range(255, 0)));
                end
            endcase
            mode = p % 4;
            sender_idle    = (mode == 1) ? 64 : (mode == 3) ? 21 : 0;
            receiver_stall = (mode == 2) ? 64 : (mode == 3) ? 21 : 0;
            build_stream(PHASE_LEN);
            if (p == 0)
                pressure_on = 1'b1;
            while (byte_stream.size() != 0)
            begin
                b = byte_stream.pop_front();
                send_word(b, 1'b0, frame_word_t'{KIND_DATA, 8'h00, 8'h00});
            end
        end

        settle();
        mismatches += pending_words.size();
        $display("%0d bytes in, %0d words: %0d payload, %0d good, %0d too long, %0d bad end",
                 bytes_in, words_out, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("covered %0d register settings, four idle mixes and one long output hold-off",
                 NUM_PHASES + 2);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
